// File: rtl/rcpd_pkg.sv
// Package with shared types, codes and constants of the RC PWM pulse decoder.
package rcpd_pkg;

	// Item operation codes.
	typedef enum logic {
		OP_EDGE = 1'b0,
		OP_POLL = 1'b1
	} op_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_TIMEOUT_MS = 2'd0,
		REG_OUT_MIN    = 2'd1,
		REG_OUT_MAX    = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [15:0]        TIMEOUT_RESET = 16'd100;
	localparam logic signed [15:0] OUT_MIN_RESET = 16'sd0;
	localparam logic signed [15:0] OUT_MAX_RESET = 16'sd1000;

	// Width windows in us.
	localparam logic [31:0] ACCEPT_MIN_US  = 32'd800;
	localparam logic [31:0] ACCEPT_MAX_US  = 32'd2200;
	localparam logic [11:0] PRESENT_MIN_US = 12'd900;
	localparam logic [11:0] PRESENT_MAX_US = 12'd2100;
	localparam logic [11:0] MAP_LOW_US     = 12'd1000;
	localparam logic [11:0] MAP_HIGH_US    = 12'd2000;
	localparam logic [9:0]  MAP_SPAN_US    = 10'd1000;

	// Reciprocals of 125 for divide-by-1000 after dropping three low bits.
	// Age: 29-bit dividend, shift 36. Map: 23-bit dividend, shift 29.
	localparam logic [29:0] AGE_RECIP = 30'd549755814;
	localparam int unsigned AGE_SHIFT = 36;
	localparam logic [22:0] MAP_RECIP = 23'd4294968;
	localparam int unsigned MAP_SHIFT = 29;

	typedef struct packed {
		op_t         operation;
		logic        level;
		logic [31:0] now_us;
	} event_t;

	typedef struct packed {
		logic [11:0]        pulse_width;
		logic               pulse_seen;
		logic [22:0]        age_ms;
		logic               signal_present;
		logic signed [15:0] mapped_value;
	} result_t;

	// What the capture stage hands to the arithmetic stages.
	typedef struct packed {
		logic [28:0] diff_hi;   // (now - last good stamp) >> 3
		logic        seen;
		logic [11:0] held;
		logic        width_ok;  // held width in presence window
		logic [9:0]  w_off;     // clamped width minus low end
	} cap_t;

endpackage

// File: rtl/rcpd_stream_if.sv
// Valid/ready stream interface carrying one payload item.
interface rcpd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/rc_pwm_pulse_decoder.sv
// Top level of the RC PWM pulse decoder: capture plus mapping pipeline.
//
//  channel   dir   handshake          payload
//  events    in    valid/ready        operation, level, now_us
//  results   out   valid/ready        pulse_width, pulse_seen, age_ms,
//                                     signal_present, mapped_value
//  cfg       in    cfg_we (no ready)  cfg_index, cfg_wdata
//
// Four register stages: input (s1), capture (s2), divide/multiply (s3), result (s4).
// One item per cycle while results are taken; result valid rises when the item reaches s4.
// The divide-by-1000 reciprocal multiplies in s2 and s3 set the stage count.
// Reset clears the capture state and all stage valids, and loads config reset values.
// Each stage fills whenever its successor is empty or moving, so a stalled result
// still lets up to three more items enter.
module rc_pwm_pulse_decoder import rcpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	rcpd_stream_if.sink           events,
	rcpd_stream_if.source         results
);

	// Configuration registers.
	logic [15:0]        timeout_q;
	logic signed [15:0] out_min_q;
	logic signed [15:0] out_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			out_min_q <= OUT_MIN_RESET;
			out_max_q <= OUT_MAX_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_TIMEOUT_MS: timeout_q <= cfg_wdata;
				REG_OUT_MIN:    out_min_q <= signed'(cfg_wdata);
				REG_OUT_MAX:    out_max_q <= signed'(cfg_wdata);
				default:        ; // drop writes to unknown indexes
			endcase
		end
	end

	// Stage valids and advance terms: a stage moves when its successor has room.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv1, adv2, adv3, adv4;

	assign adv4 = !valid_s4 || results.ready;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign events.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= events.valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
		end
	end

	// s1: input register.
	event_t item_s1;

	always_ff @(posedge clk) begin
		if (adv1 && events.valid) begin
			item_s1 <= events.data;
		end
	end

	// Capture state commits as the item leaves s1, so the next item sees it.
	cap_t cap;

	rcpd_capture u_capture (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (valid_s1 && adv2),
		.item   (item_s1),
		.cap    (cap)
	);

	// s2: captured view of the state.
	cap_t cap_s2;

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			cap_s2 <= cap;
		end
	end

	// s2 logic: age reciprocal multiply, and numerator of the linear map.
	logic [58:0]        age_prod;
	logic [22:0]        age;
	logic signed [16:0] span;
	logic signed [27:0] span_prod;
	logic signed [27:0] base;
	logic signed [27:0] num;

	always_comb begin
		age_prod  = 59'(cap_s2.diff_hi) * 59'(AGE_RECIP);
		age       = cap_s2.seen ? age_prod[58:AGE_SHIFT] : '0;
		span      = 17'(out_max_q) - 17'(out_min_q);
		span_prod = 28'(span) * signed'(28'(cap_s2.w_off));
		base      = 28'(out_min_q) * 28'sd1000;
		num       = base + span_prod;
	end

	logic [22:0]        age_s3;
	logic               seen_s3;
	logic [11:0]        held_s3;
	logic               width_ok_s3;
	logic signed [26:0] num_s3;

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			age_s3      <= age;
			seen_s3     <= cap_s2.seen;
			held_s3     <= cap_s2.held;
			width_ok_s3 <= cap_s2.width_ok;
			num_s3      <= 27'(num);
		end
	end

	// s3 logic: divide magnitude by 1000, restore sign (truncate toward zero).
	logic        neg;
	logic [26:0] mag;
	logic [45:0] quot_prod;
	logic [16:0] quot;
	logic [15:0] mapped;
	logic        present;

	always_comb begin
		neg       = num_s3[26];
		mag       = neg ? 27'(-num_s3) : 27'(num_s3);
		quot_prod = 46'(mag[25:3]) * 46'(MAP_RECIP);
		quot      = quot_prod[45:MAP_SHIFT];
		mapped    = neg ? 16'(-quot) : 16'(quot);
		present   = seen_s3 && (age_s3 <= 23'(timeout_q)) && width_ok_s3;
	end

	// s4: result register.
	result_t res_s4;

	always_ff @(posedge clk) begin
		if (adv4 && valid_s3) begin
			res_s4.pulse_width    <= held_s3;
			res_s4.pulse_seen     <= seen_s3;
			res_s4.age_ms         <= age_s3;
			res_s4.signal_present <= present;
			res_s4.mapped_value   <= signed'(mapped);
		end
	end

	assign results.valid = valid_s4;
	assign results.data  = res_s4;

endmodule

// File: rtl/rcpd_capture.sv
// Edge capture: holds rise/last-good stamps, held width and seen flag.
module rcpd_capture import rcpd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   commit,
	input  event_t item,
	output cap_t   cap
);

	logic [31:0] rise_q;
	logic [31:0] last_good_q;
	logic [11:0] held_q;
	logic        seen_q;

	logic        is_rise;
	logic        is_fall;
	logic [31:0] width;
	logic        good;
	logic [11:0] held_new;
	logic [31:0] last_new;
	logic        seen_new;
	logic [31:0] diff;

	always_comb begin
		is_rise  = (item.operation == OP_EDGE) && item.level;
		is_fall  = (item.operation == OP_EDGE) && !item.level;
		width    = item.now_us - rise_q;
		good     = is_fall && (width >= ACCEPT_MIN_US) && (width <= ACCEPT_MAX_US);
		held_new = good ? width[11:0] : held_q;
		last_new = good ? item.now_us : last_good_q;
		seen_new = seen_q | good;
		diff     = item.now_us - last_new;
	end

	always_comb begin
		cap.diff_hi  = diff[31:3];
		cap.seen     = seen_new;
		cap.held     = held_new;
		cap.width_ok = (held_new >= PRESENT_MIN_US) && (held_new <= PRESENT_MAX_US);
		if (held_new < MAP_LOW_US) begin
			cap.w_off = '0;
		end else if (held_new > MAP_HIGH_US) begin
			cap.w_off = MAP_SPAN_US;
		end else begin
			cap.w_off = 10'(held_new - MAP_LOW_US);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q      <= '0;
			last_good_q <= '0;
			held_q      <= '0;
			seen_q      <= 1'b0;
		end else if (commit) begin
			if (is_rise) begin
				rise_q <= item.now_us;
			end
			last_good_q <= last_new;
			held_q      <= held_new;
			seen_q      <= seen_new;
		end
	end

endmodule

// File: rtl/rcpd_checker.sv
// Port checker for the RC PWM pulse decoder, bound to the top level.
module rcpd_checker import rcpd_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    res_valid,
	input logic    res_ready,
	input result_t res_data
);

	// Hold the seen flag of the last delivered result.
	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			seen_q <= res_data.pulse_seen;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && seen_q |-> res_data.pulse_seen)
		else $error("pulse_seen cleared after being set");

	a_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.pulse_seen |->
			res_data.pulse_width == 12'd0 && res_data.age_ms == 23'd0 &&
			!res_data.signal_present)
		else $error("fields nonzero before any pulse");

	a_present_window: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.signal_present |->
			res_data.pulse_seen && res_data.pulse_width >= PRESENT_MIN_US &&
			res_data.pulse_width <= PRESENT_MAX_US)
		else $error("signal_present outside width window");

	a_width_window: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.pulse_seen |->
			32'(res_data.pulse_width) >= ACCEPT_MIN_US &&
			32'(res_data.pulse_width) <= ACCEPT_MAX_US)
		else $error("held width outside accept window");

endmodule

bind rc_pwm_pulse_decoder rcpd_checker u_rcpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_data  (results.data)
);

// File: tb/tb.sv
// Self-checking bench for the RC PWM pulse decoder: directed and random pin events, checked per item.
module tb;
	import rcpd_pkg::*;

	// Clock, reset and the configuration port.
	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we = 1'b0;
	reg_idx_t              cfg_index = REG_TIMEOUT_MS;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	rcpd_stream_if #(.payload_t(event_t))  ev_ch ();
	rcpd_stream_if #(.payload_t(result_t)) res_ch ();

	rc_pwm_pulse_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.events    (ev_ch),
		.results   (res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Pin events waiting to be sent, and the readings they must produce, oldest first.
	event_t  pin_events[$];
	result_t predicted_readings[$];
	result_t want_reading;

	// Idle chances in percent for the event sender and the result receiver.
	int unsigned src_idle_pct = 0;
	int unsigned sink_idle_pct = 0;
	int unsigned bad_fields = 0;

	// Shadow copy of the decoder registers and capture state.
	logic [15:0]        cfg_timeout = TIMEOUT_RESET;
	logic signed [15:0] cfg_out_min = OUT_MIN_RESET;
	logic signed [15:0] cfg_out_max = OUT_MAX_RESET;
	logic [31:0]        rise_stamp = '0;
	logic [11:0]        held_width = '0;
	logic [31:0]        last_good_stamp = '0;
	logic               pulse_seen = 1'b0;

	// Stimulus time cursor and the time of the last falling edge sent in a full rise/fall pulse.
	logic [31:0] clock_us = '0;
	logic [31:0] last_fall_us = '0;
	int unsigned queued_items = 0;

	// Advance the shadow capture state by one event and return the reading it yields.
	function automatic result_t decode_reading(event_t ev);
		result_t     r;
		logic [31:0] high_time;
		logic [31:0] age;
		logic [11:0] w;
		longint      num;
		longint      mapped;
		if (ev.operation == OP_EDGE) begin
			if (ev.level) begin
				rise_stamp = ev.now_us;
			end else begin
				// Wrapping subtraction; a fall with no rise measures against the old stamp.
				high_time = ev.now_us - rise_stamp;
				if (high_time >= ACCEPT_MIN_US && high_time <= ACCEPT_MAX_US) begin
					held_width = high_time[11:0];
					last_good_stamp = ev.now_us;
					pulse_seen = 1'b1;
				end
			end
		end
		age = pulse_seen ? (ev.now_us - last_good_stamp) / 32'd1000 : 32'd0;
		// Clamp to the mapping window, then scale; signed divide truncates toward zero.
		w = held_width;
		if (w < MAP_LOW_US)
			w = MAP_LOW_US;
		if (w > MAP_HIGH_US)
			w = MAP_HIGH_US;
		num = longint'(cfg_out_min) * longint'(MAP_SPAN_US) +
			(longint'(cfg_out_max) - longint'(cfg_out_min)) * longint'(w - MAP_LOW_US);
		mapped = num / longint'(MAP_SPAN_US);
		r.pulse_width    = held_width;
		r.pulse_seen     = pulse_seen;
		r.age_ms         = age[22:0];
		r.signal_present = pulse_seen && age <= {16'd0, cfg_timeout} &&
			held_width >= PRESENT_MIN_US && held_width <= PRESENT_MAX_US;
		r.mapped_value   = mapped[15:0];
		return r;
	endfunction

	task automatic note_field(string field, longint want, longint got);
		bad_fields++;
		if (bad_fields <= 10)
			$display("tb: %s mismatch at %0t: expected %0d, got %0d", field, $realtime,
				want, got);
	endtask

	// Sender: hold an item until it is taken, record its reading on acceptance,
	// then offer the next one unless this cycle idles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_ch.valid <= 1'b0;
		end else begin
			if (ev_ch.valid && ev_ch.ready)
				predicted_readings.push_back(decode_reading(ev_ch.data));
			if (!ev_ch.valid || ev_ch.ready) begin
				if (pin_events.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					ev_ch.valid <= 1'b1;
					ev_ch.data  <= pin_events.pop_front();
				end else begin
					ev_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each accepted reading against the oldest prediction, field by field.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (predicted_readings.size() == 0) begin
					bad_fields++;
					if (bad_fields <= 10)
						$display("tb: reading at %0t with none predicted", $realtime);
				end else begin
					want_reading = predicted_readings.pop_front();
					if (res_ch.data.pulse_width !== want_reading.pulse_width)
						note_field("pulse_width", want_reading.pulse_width,
							res_ch.data.pulse_width);
					if (res_ch.data.pulse_seen !== want_reading.pulse_seen)
						note_field("pulse_seen", want_reading.pulse_seen,
							res_ch.data.pulse_seen);
					if (res_ch.data.age_ms !== want_reading.age_ms)
						note_field("age_ms", want_reading.age_ms, res_ch.data.age_ms);
					if (res_ch.data.signal_present !== want_reading.signal_present)
						note_field("signal_present", want_reading.signal_present,
							res_ch.data.signal_present);
					if (res_ch.data.mapped_value !== want_reading.mapped_value)
						note_field("mapped_value", want_reading.mapped_value,
							res_ch.data.mapped_value);
				end
			end
			res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic push_item(op_t op, logic level, logic [31:0] stamp);
		event_t ev;
		ev.operation = op;
		ev.level     = level;
		ev.now_us    = stamp;
		pin_events.push_back(ev);
		queued_items++;
	endtask

	// Write a register; the shadow copy follows at once since the decoder is idle.
	// Leave cfg_we high so back-to-back writes need no drop in between.
	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_TIMEOUT_MS: cfg_timeout = value;
			REG_OUT_MIN:    cfg_out_min = value;
			REG_OUT_MAX:    cfg_out_max = value;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait for every item sent and every reading returned, then let the pipe settle.
	task automatic wait_idle();
		while (pin_events.size() != 0 || predicted_readings.size() != 0 || ev_ch.valid)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Mostly legal servo widths, with the window edges and wild values mixed in.
	function automatic logic [31:0] pick_width();
		logic [31:0] edges [16] = '{799, 800, 899, 900, 999, 1000, 1001, 1999,
			2000, 2001, 2099, 2100, 2101, 2199, 2200, 2201};
		case ($urandom_range(0, 5))
			0:       return edges[$urandom_range(0, 15)];
			1:       return $urandom_range(0, 4095);
			5:       return $urandom_range(800, 2200);
			default: return $urandom_range(900, 2100);
		endcase
	endfunction

	// One random burst: mostly a full rise/fall pulse with trailing polls,
	// else a poll near the timeout, a long jump, or a stray edge.
	task automatic add_random_frame();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			clock_us += $urandom_range(3000, 30000);
			push_item(OP_EDGE, 1'b1, clock_us);
			clock_us += pick_width();
			last_fall_us = clock_us;
			push_item(OP_EDGE, 1'b0, clock_us);
			repeat ($urandom_range(0, 2)) begin
				clock_us += $urandom_range(0, 20000);
				push_item(OP_POLL, 1'($urandom_range(1)), clock_us);
			end
		end else if (pick < 82) begin
			// Land the age right around the timeout.
			clock_us = last_fall_us + cfg_timeout * 32'd1000 + $urandom_range(0, 2000) - 32'd1000;
			push_item(OP_POLL, 1'($urandom_range(1)), clock_us);
		end else if (pick < 90) begin
			clock_us += $urandom;
			push_item(OP_POLL, 1'($urandom_range(1)), clock_us);
		end else begin
			clock_us = $urandom;
			push_item(OP_EDGE, 1'($urandom_range(1)), clock_us);
		end
	endtask

	task automatic run_random(int unsigned count);
		queued_items = 0;
		while (queued_items < count)
			add_random_frame();
		wait_idle();
	endtask

	initial begin
		ev_ch.valid  = 1'b0;
		ev_ch.data   = '0;
		res_ch.ready = 1'b0;
		arst_n       = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass on reset settings: timeout 100 ms, map 0..1000.
		push_item(OP_POLL, 1'b0, 32'd0);            // nothing captured yet
		push_item(OP_POLL, 1'b1, 32'hFFFF_FFFF);
		push_item(OP_EDGE, 1'b0, 32'd900);          // fall with no rise: 900 us kept
		push_item(OP_POLL, 1'b0, 32'd100_900);      // age exactly at timeout
		push_item(OP_POLL, 1'b0, 32'd101_899);
		push_item(OP_POLL, 1'b0, 32'd101_900);      // one ms past timeout
		push_item(OP_EDGE, 1'b1, 32'hFFFF_F830);
		push_item(OP_EDGE, 1'b0, 32'd0);            // pulse wraps and ends at time zero
		push_item(OP_POLL, 1'b0, 32'd999);
		push_item(OP_EDGE, 1'b1, 32'd200_000);
		push_item(OP_EDGE, 1'b0, 32'd200_799);      // just too short, dropped
		push_item(OP_EDGE, 1'b1, 32'd300_000);
		push_item(OP_EDGE, 1'b0, 32'd302_201);      // just too long, dropped
		push_item(OP_EDGE, 1'b0, 32'd300_800);      // shortest kept, below presence window
		push_item(OP_EDGE, 1'b1, 32'd400_000);
		push_item(OP_EDGE, 1'b0, 32'd402_200);      // longest kept, map clamps high
		push_item(OP_EDGE, 1'b1, 32'd600_000);
		push_item(OP_EDGE, 1'b0, 32'd600_900);
		push_item(OP_EDGE, 1'b1, 32'd700_000);
		push_item(OP_EDGE, 1'b0, 32'd702_100);
		push_item(OP_EDGE, 1'b1, 32'd800_000);
		push_item(OP_EDGE, 1'b0, 32'd802_101);      // kept but outside presence window
		push_item(OP_EDGE, 1'b1, 32'd900_000);
		push_item(OP_EDGE, 1'b0, 32'd901_500);
		push_item(OP_POLL, 1'b1, 32'd901_600);
		wait_idle();

		// Extreme range, zero timeout; slow receiver. Start near the wrap point.
		write_reg(REG_TIMEOUT_MS, 16'd0);
		write_reg(REG_OUT_MIN, 16'h8000);
		write_reg(REG_OUT_MAX, 16'h7FFF);
		write_reg(REG_UNUSED, 16'($urandom));
		end_writes();
		src_idle_pct  = 23;
		sink_idle_pct = 82;
		clock_us      = 32'hFFF0_0000;
		last_fall_us  = clock_us;
		run_random(460);

		// Inverted range, longest timeout; slow sender.
		write_reg(REG_TIMEOUT_MS, 16'hFFFF);
		write_reg(REG_OUT_MIN, 16'h7FFF);
		write_reg(REG_OUT_MAX, 16'h8000);
		end_writes();
		src_idle_pct  = 82;
		sink_idle_pct = 23;
		run_random(460);

		// Random settings at full rate.
		write_reg(REG_TIMEOUT_MS, 16'($urandom_range(20, 300)));
		write_reg(REG_OUT_MIN, 16'($urandom));
		write_reg(REG_OUT_MAX, 16'($urandom));
		end_writes();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		run_random(460);

		if (bad_fields == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	// Hang guard, far beyond the slowest legal run.
	initial begin
		#(12 * 400000);
		$display("tb: done, errors");
		$finish;
	end

endmodule

// File: sim.f
rtl/rcpd_pkg.sv
rtl/rcpd_stream_if.sv
rtl/rcpd_capture.sv
rtl/rc_pwm_pulse_decoder.sv
rtl/rcpd_checker.sv
tb/tb.sv
